/* src/mandel_pkg.sv */
// shared constants, types and register codes for the escape-time pixel unit
package mandel_pkg;

    // fixed-point formats
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int ITER_LIMIT  = 1023;

    // field widths
    localparam int PIX_WIDTH   = 12;
    localparam int ZOOM_WIDTH  = 31;
    localparam int CNT_WIDTH   = 10;
    localparam int COLOR_WIDTH = 8;

    // shared multiplier and iteration widths
    localparam int MUL_WIDTH  = 32;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;
    localparam int Z_WIDTH    = COORD_WIDTH + 2;
    localparam int DIFF_WIDTH = PIX_WIDTH + 2;

    // colour divider
    localparam int DIVIDEND_WIDTH = CNT_WIDTH + COLOR_WIDTH;
    localparam int STEP_WIDTH     = $clog2(DIVIDEND_WIDTH);

    // stream payloads
    localparam int IN_FIELDS_WIDTH  = 2 * PIX_WIDTH;
    localparam int IN_DATA_WIDTH    = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_WIDTH = CNT_WIDTH + 1 + 3 * COLOR_WIDTH;
    localparam int OUT_DATA_WIDTH   = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;

    // register reset values
    localparam logic [ZOOM_WIDTH-1:0]         ZOOM_RESET   = ZOOM_WIDTH'(1342177);
    localparam logic signed [COORD_WIDTH-1:0] OFF_RE_RESET = -COORD_WIDTH'(134217728);
    localparam logic signed [COORD_WIDTH-1:0] OFF_IM_RESET = '0;
    localparam logic [CNT_WIDTH-1:0]          MAX_IT_RESET = CNT_WIDTH'(100);
    localparam logic [PIX_WIDTH-1:0]          WIDTH_RESET  = PIX_WIDTH'(800);
    localparam logic [PIX_WIDTH-1:0]          HEIGHT_RESET = PIX_WIDTH'(600);

    // coordinate saturation bounds
    localparam logic signed [PROD_WIDTH-1:0] COORD_MAX =
        (PROD_WIDTH'(1) << (COORD_WIDTH - 1)) - PROD_WIDTH'(1);
    localparam logic signed [PROD_WIDTH-1:0] COORD_MIN = -COORD_MAX - PROD_WIDTH'(1);

    // any part beyond two already escapes, so it never reaches the multiplier
    localparam logic signed [Z_WIDTH-1:0] Z_BOUND     = Z_WIDTH'(1) << (FRAC_BITS + 1);
    localparam logic signed [Z_WIDTH-1:0] Z_BOUND_NEG = -Z_BOUND;

    // escape radius squared (4.0 at product scale)
    localparam logic signed [PROD_WIDTH-1:0] ESC_RADIUS_SQ =
        PROD_WIDTH'(1) << (2 * FRAC_BITS + 2);

    localparam logic [COLOR_WIDTH-1:0] COLOR_FULL = '1;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_ZOOM_STEP      = 3'd0,
        REG_OFFSET_REAL    = 3'd1,
        REG_OFFSET_IMAG    = 3'd2,
        REG_MAX_ITERATIONS = 3'd3,
        REG_SCREEN_WIDTH   = 3'd4,
        REG_SCREEN_HEIGHT  = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_MAP_C,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

/* src/mandel_mult.sv */
// shared signed multiplier with registered product
module mandel_mult import mandel_pkg::*; (
    input  logic                         aclk,
    input  logic signed [MUL_WIDTH-1:0]  mul_a,
    input  logic signed [MUL_WIDTH-1:0]  mul_b,
    output logic signed [PROD_WIDTH-1:0] prod
);

    logic signed [PROD_WIDTH-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

/* src/mandel_div.sv */
// bit-serial restoring divider for the colour ramp
module mandel_div import mandel_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [CNT_WIDTH-1:0]      divisor,
    output logic                      done,
    output logic [DIVIDEND_WIDTH-1:0] quotient
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [STEP_WIDTH-1:0]     step_reg;
    logic [CNT_WIDTH-1:0]      rem_reg;
    logic [DIVIDEND_WIDTH-1:0] quo_reg;
    logic [CNT_WIDTH-1:0]      den_reg;

    logic [CNT_WIDTH:0] trial;
    logic [CNT_WIDTH:0] trial_sub;
    logic               fits;

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    always_comb begin
        trial     = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_WIDTH'(DIVIDEND_WIDTH - 1);
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg - STEP_WIDTH'(1);
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[CNT_WIDTH-1:0] : trial[CNT_WIDTH-1:0];
            quo_reg <= {quo_reg[DIVIDEND_WIDTH-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/mandelbrot_escape_time_pixel.sv */
// escape-time pixel unit: maps a pixel to c, iterates z = z*z + c, colours the count
//
// one item carries a pixel (pixel_x, pixel_y); one result item comes back with the
// iteration count, an inside flag and an rgb colour. the pixel is mapped to
// c = floor((2*pixel - size) * zoom_step / 2) + offset, saturated to signed q4.28,
// then z is iterated from zero while |z|^2 <= 4 and count < max_iterations. every
// product of the mapping and the iteration comes from one registered 32x32 signed
// multiplier: the map_x, map_y and map_c states map the pixel, each iteration steps
// through zr^2, zi^2, zr*zi, then update, and the check that opens a step ends the
// loop when the limit is hit or a part already lies beyond two, and otherwise needs
// the squares. an escaped pixel then goes through a bit-serial divider forming
// k*255/max_iterations for the colour ramp; a pixel inside the set skips it and is
// black. the unit holds one item at a time and s_tready is high only while idle,
// but a finished result sits in the output register so the next item is taken
// while it waits for m_tready.
// configuration is a plain write port (index per register below) and must only
// be written while the unit is idle:
//   0 zoom_step, 1 offset_real, 2 offset_imag, 3 max_iterations,
//   4 screen_width, 5 screen_height
module mandelbrot_escape_time_pixel import mandel_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration writes
    input  logic                      cfg_wr_en,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,

    // pixel items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // pixel_x, pixel_y

    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_WIDTH-1:0] m_tdata    // iteration_count, inside_set, red, green, blue
);

    // configuration registers
    logic [ZOOM_WIDTH-1:0]         zoom_reg;
    logic signed [COORD_WIDTH-1:0] off_re_reg;
    logic signed [COORD_WIDTH-1:0] off_im_reg;
    logic [CNT_WIDTH-1:0]          max_it_reg;
    logic [PIX_WIDTH-1:0]          width_reg;
    logic [PIX_WIDTH-1:0]          height_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // datapath registers
    logic [PIX_WIDTH-1:0]          px_reg;
    logic [PIX_WIDTH-1:0]          py_reg;
    logic signed [COORD_WIDTH-1:0] cr_reg;
    logic signed [COORD_WIDTH-1:0] ci_reg;
    logic signed [Z_WIDTH-1:0]     zr_reg;
    logic signed [Z_WIDTH-1:0]     zi_reg;
    logic signed [PROD_WIDTH-1:0]  rr_reg;
    logic signed [PROD_WIDTH-1:0]  diff_reg;
    logic                          esc_reg;
    logic [CNT_WIDTH-1:0]          k_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [CNT_WIDTH-1:0]   count_out_reg;
    logic                   inside_out_reg;
    logic [COLOR_WIDTH-1:0] red_out_reg;
    logic [COLOR_WIDTH-1:0] green_out_reg;
    logic [COLOR_WIDTH-1:0] blue_out_reg;

    // sequencer outputs
    logic                         in_ready;
    logic                         div_start;
    logic                         load_out;
    logic signed [MUL_WIDTH-1:0]  mul_a;
    logic signed [MUL_WIDTH-1:0]  mul_b;

    // shared multiplier and divider
    logic signed [PROD_WIDTH-1:0]  prod;
    logic                          div_done;
    logic [DIVIDEND_WIDTH-1:0]     div_quo;
    logic [DIVIDEND_WIDTH-1:0]     div_num;

    // combinational datapath
    logic signed [DIFF_WIDTH-1:0]  dx;
    logic signed [DIFF_WIDTH-1:0]  dy;
    logic signed [PROD_WIDTH-1:0]  map_half;
    logic signed [PROD_WIDTH-1:0]  map_off;
    logic signed [PROD_WIDTH-1:0]  map_sum;
    logic signed [COORD_WIDTH-1:0] map_coord;
    logic signed [PROD_WIDTH-1:0]  mag_sum;
    logic signed [PROD_WIDTH-1:0]  sq_diff;
    logic signed [PROD_WIDTH-1:0]  diff_shift;
    logic signed [PROD_WIDTH-1:0]  cross_shift;
    logic signed [Z_WIDTH-1:0]     zr_update;
    logic signed [Z_WIDTH-1:0]     zi_update;
    logic [CNT_WIDTH-1:0]          eff_limit;
    logic                          limit_hit;
    logic                          z_big;
    logic [COLOR_WIDTH-1:0]        q;

    logic in_accept;
    logic out_accept;

    assign in_accept  = s_tvalid && in_ready;
    assign out_accept = m_tvalid_reg && m_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg   <= ZOOM_RESET;
            off_re_reg <= OFF_RE_RESET;
            off_im_reg <= OFF_IM_RESET;
            max_it_reg <= MAX_IT_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ZOOM_STEP:      zoom_reg   <= cfg_wdata[ZOOM_WIDTH-1:0];
                REG_OFFSET_REAL:    off_re_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_OFFSET_IMAG:    off_im_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_MAX_ITERATIONS: max_it_reg <= cfg_wdata[CNT_WIDTH-1:0];
                REG_SCREEN_WIDTH:   width_reg  <= cfg_wdata[PIX_WIDTH-1:0];
                REG_SCREEN_HEIGHT:  height_reg <= cfg_wdata[PIX_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective limit and escape conditions
    always_comb begin
        eff_limit = (max_it_reg < CNT_WIDTH'(ITER_LIMIT)) ? max_it_reg
                                                          : CNT_WIDTH'(ITER_LIMIT);
        limit_hit = k_reg >= eff_limit;
        // a part beyond two means |z|^2 > 4 without multiplying
        z_big = (zr_reg > Z_BOUND) || (zr_reg < Z_BOUND_NEG) ||
                (zi_reg > Z_BOUND) || (zi_reg < Z_BOUND_NEG);
    end

    // pixel to complex mapping, one axis at a time through the multiplier
    always_comb begin
        dx       = {1'b0, px_reg, 1'b0} - {2'b00, width_reg};
        dy       = {1'b0, py_reg, 1'b0} - {2'b00, height_reg};
        map_half = prod >>> 1;
        map_off  = (state_reg == ST_MAP_Y)
                 ? {{(PROD_WIDTH-COORD_WIDTH){off_re_reg[COORD_WIDTH-1]}}, off_re_reg}
                 : {{(PROD_WIDTH-COORD_WIDTH){off_im_reg[COORD_WIDTH-1]}}, off_im_reg};
        map_sum  = map_half + map_off;
        if (map_sum > COORD_MAX) begin
            map_coord = COORD_MAX[COORD_WIDTH-1:0];
        end else if (map_sum < COORD_MIN) begin
            map_coord = COORD_MIN[COORD_WIDTH-1:0];
        end else begin
            map_coord = map_sum[COORD_WIDTH-1:0];
        end
    end

    // iteration arithmetic around the multiplier output
    always_comb begin
        mag_sum     = rr_reg + prod;
        sq_diff     = rr_reg - prod;
        diff_shift  = diff_reg >>> FRAC_BITS;
        // doubling the cross term is one less bit of shift
        cross_shift = prod >>> (FRAC_BITS - 1);
        zr_update   = diff_shift[Z_WIDTH-1:0] +
                      {{(Z_WIDTH-COORD_WIDTH){cr_reg[COORD_WIDTH-1]}}, cr_reg};
        zi_update   = cross_shift[Z_WIDTH-1:0] +
                      {{(Z_WIDTH-COORD_WIDTH){ci_reg[COORD_WIDTH-1]}}, ci_reg};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MAP_X;
                end
            end
            ST_MAP_X:  state_next = ST_MAP_Y;
            ST_MAP_Y:  state_next = ST_MAP_C;
            ST_MAP_C:  state_next = ST_SQ_R;
            ST_SQ_R: begin
                if (limit_hit) begin
                    state_next = ST_DONE;
                end else if (z_big) begin
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_SQ_I;
                end
            end
            ST_SQ_I:   state_next = ST_CROSS;
            ST_CROSS:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = esc_reg ? ST_DIVIDE : ST_SQ_R;
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs, multiplier operand select
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_MAP_X: begin
                mul_a = {{(MUL_WIDTH-DIFF_WIDTH){dx[DIFF_WIDTH-1]}}, dx};
                mul_b = {1'b0, zoom_reg};
            end
            ST_MAP_Y: begin
                mul_a = {{(MUL_WIDTH-DIFF_WIDTH){dy[DIFF_WIDTH-1]}}, dy};
                mul_b = {1'b0, zoom_reg};
            end
            ST_SQ_R: begin
                mul_a     = zr_reg[MUL_WIDTH-1:0];
                mul_b     = zr_reg[MUL_WIDTH-1:0];
                div_start = !limit_hit && z_big;
            end
            ST_SQ_I: begin
                mul_a = zi_reg[MUL_WIDTH-1:0];
                mul_b = zi_reg[MUL_WIDTH-1:0];
            end
            ST_CROSS: begin
                mul_a = zr_reg[MUL_WIDTH-1:0];
                mul_b = zi_reg[MUL_WIDTH-1:0];
            end
            ST_UPDATE: div_start = esc_reg;
            ST_DONE:   load_out  = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            px_reg <= s_tdata[PIX_WIDTH-1:0];
            py_reg <= s_tdata[2*PIX_WIDTH-1:PIX_WIDTH];
        end
        case (state_reg)
            ST_MAP_Y:  cr_reg <= map_coord;
            ST_MAP_C: begin
                ci_reg <= map_coord;
                zr_reg <= '0;
                zi_reg <= '0;
                k_reg  <= '0;
            end
            ST_SQ_I:   rr_reg <= prod;
            ST_CROSS: begin
                esc_reg  <= mag_sum > ESC_RADIUS_SQ;
                diff_reg <= sq_diff;
            end
            ST_UPDATE: begin
                if (!esc_reg) begin
                    zr_reg <= zr_update;
                    zi_reg <= zi_update;
                    k_reg  <= k_reg + CNT_WIDTH'(1);
                end
            end
            default: begin
            end
        endcase
    end

    mandel_mult u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // k*255 as a shift and subtract
    assign div_num = {k_reg, {COLOR_WIDTH{1'b0}}} - {{COLOR_WIDTH{1'b0}}, k_reg};

    mandel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (eff_limit),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign q = div_quo[COLOR_WIDTH-1:0];

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (out_accept) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            count_out_reg  <= k_reg;
            inside_out_reg <= limit_hit;
            if (limit_hit) begin
                red_out_reg   <= '0;
                green_out_reg <= '0;
                blue_out_reg  <= '0;
            end else begin
                red_out_reg   <= COLOR_FULL - q;
                green_out_reg <= COLOR_FULL - (q >> 1);
                blue_out_reg  <= q;
            end
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_WIDTH-OUT_FIELDS_WIDTH){1'b0}},
                       blue_out_reg, green_out_reg, red_out_reg,
                       inside_out_reg, count_out_reg};

    // the count never runs past the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQ_I |-> k_reg < eff_limit)
        else $error("iteration count passed the limit");

    // only an in-range z reaches the multiplier as a square
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQ_I |-> (zr_reg <= Z_BOUND) && (zr_reg >= Z_BOUND_NEG) &&
                                 (zi_reg <= Z_BOUND) && (zi_reg >= Z_BOUND_NEG))
        else $error("z operand out of multiplier range");

    // the divider only runs for escaped pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !limit_hit)
        else $error("divider started for a pixel inside the set");

    // a new result appears only from the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

    // inside results are black
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && inside_out_reg |->
            red_out_reg == '0 && green_out_reg == '0 && blue_out_reg == '0)
        else $error("inside result carries a colour");

endmodule
